// ===== sv/rational_arithmetic_unit_assert.svh =====
// Assertion macros shared by the rational arithmetic unit files.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define RAU_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define RAU_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`endif

// ===== sv/rau_pkg.sv =====
// Shared types and constants of the rational arithmetic unit.
package rau_pkg;
    localparam int NUM_W = 33;
    localparam int DEN_W = 31;
    localparam int MAG_W = 66;

    localparam logic [2:0] KIND_ADD = 3'd0;
    localparam logic [2:0] KIND_SUB = 3'd1;
    localparam logic [2:0] KIND_MUL = 3'd2;
    localparam logic [2:0] KIND_DIV = 3'd3;
    localparam logic [2:0] KIND_SCL = 3'd4;
    localparam logic [2:0] KIND_CMP = 3'd5;

    typedef struct packed {
        logic start;
        logic done;
    } divctl_t;
endpackage

// ===== sv/rau_divider.sv =====
// Shared restoring divider: one quotient bit per cycle, gives quotient and remainder.
`include "rational_arithmetic_unit_assert.svh"
module rau_divider #(
    parameter int W = 66
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [W-1:0]         dividend,
    input  logic [W-1:0]         divisor,
    output logic                 done,
    output logic [W-1:0]         quot,
    output logic [W-1:0]         rem
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;
    logic [W:0]    shifted;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {r_reg, q_reg[W-1]};
        trial     = shifted - {1'b0, d_reg};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                r_next = trial[W-1:0];
                q_next = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_next = shifted[W-1:0];
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

    `RAU_ASSERT_IMP(a_done_ends_busy, clk, rst_n, done_reg, !busy_reg, "divider busy at done")
    `RAU_ASSERT_IMP(a_busy_cnt, clk, rst_n, busy_reg, cnt_reg != '0, "divider busy, zero count")
    `RAU_ASSERT_NEXT(a_start_busy, clk, rst_n, start, busy_reg, "divider did not start")
endmodule

// ===== sv/rational_arithmetic_unit.sv =====
// Top level of the rational arithmetic unit: sequencer around one shared divider.
//  channel | signals                                   | handshake
//  command | kind a_num a_den b_num b_den              | start when !busy
//  result  | res_num res_den is_equal is_greater       | done strobe, one cycle
//          | is_less div_zero                          |
// A beat is taken when start is high and busy is low; busy stays high until done.
// Products are registered when the beat is taken and their sum in S_PROD; the Euclid
// loop uses the divider for each remainder step, then two more divisions by the gcd
// give the reduced result before done strobes.
// Compares, zero results and undefined kinds skip the divider and strobe done from S_OUT.
// Reset clears the sequencer; the result strobe cannot be stalled.
`include "rational_arithmetic_unit_assert.svh"
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [2:0]                     kind,
    input  logic signed [15:0]             a_num,
    input  logic signed [15:0]             a_den,
    input  logic signed [15:0]             b_num,
    input  logic signed [15:0]             b_den,
    output logic                           done,
    output logic signed [rau_pkg::NUM_W-1:0] res_num,
    output logic [rau_pkg::DEN_W-1:0]      res_den,
    output logic                           is_equal,
    output logic                           is_greater,
    output logic                           is_less,
    output logic                           div_zero
);
    localparam int OW = OPERAND_WIDTH;
    localparam int MW = rau_pkg::MAG_W;

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_PROD = 8'b00000010,
        S_SUM  = 8'b00000100,
        S_GCD  = 8'b00001000,
        S_DIVN = 8'b00010000,
        S_DIVD = 8'b00100000,
        S_OUT  = 8'b01000000,
        S_WAIT = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0]    kind_reg;
    logic          an_s, ad_s, bn_s, bd_s;
    logic [OW-1:0] an_m, ad_m, bn_m, bd_m;
    logic [MW-1:0] t1_reg, t2_reg, den_reg, num_reg, gx_reg, gy_reg, gcd_reg;
    logic          t1n_reg, t2n_reg, dneg_reg, nneg_reg, dz_reg;
    logic          done_reg;
    logic signed [rau_pkg::NUM_W-1:0] rn_reg;
    logic [rau_pkg::DEN_W-1:0] rd_reg;
    logic          eq_reg, gt_reg, lt_reg;
    rau_pkg::divctl_t dctl;
    logic          dv_done;
    logic [MW-1:0] dv_a, dv_b, dv_q, dv_r;
    logic [MW-1:0] ad_w;
    logic [MW-1:0] sum_mag;
    logic          sum_neg;

    function automatic logic [OW-1:0] mag_of(input logic [15:0] raw, input logic z1);
        logic [OW-1:0] v;
        logic [OW-1:0] m;
        v = OW'(raw);
        m = v[OW-1] ? (~v + 1'b1) : v;
        if (v[OW-1] && m == '0)
            m = {1'b1, {(OW-1){1'b0}}};
        if (z1 && m == '0)
            m = OW'(1);
        return m;
    endfunction

    function automatic logic sign_of(input logic [15:0] raw, input logic z1);
        logic [OW-1:0] v;
        v = OW'(raw);
        return v[OW-1] && !(z1 && v == '0);
    endfunction

    always_comb
    begin
        an_s = sign_of(a_num, 1'b0);
        ad_s = sign_of(a_den, 1'b1);
        bn_s = sign_of(b_num, 1'b0);
        bd_s = sign_of(b_den, 1'b1);
        an_m = mag_of(a_num, 1'b0);
        ad_m = mag_of(a_den, 1'b1);
        bn_m = mag_of(b_num, 1'b0);
        bd_m = mag_of(b_den, 1'b1);
        ad_w = MW'(ad_m);
    end

    // Sign-magnitude addition of the two cross products.
    always_comb
    begin
        if (t1n_reg == t2n_reg)
        begin
            sum_neg = t1n_reg;
            sum_mag = t1_reg + t2_reg;
        end
        else if (t1_reg >= t2_reg)
        begin
            sum_neg = t1n_reg;
            sum_mag = t1_reg - t2_reg;
        end
        else
        begin
            sum_neg = t2n_reg;
            sum_mag = t2_reg - t1_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        dctl.start = 1'b0;
        dctl.done  = dv_done;
        dv_a       = gx_reg;
        dv_b       = gy_reg;
        case (state_reg)
            S_IDLE: if (start) state_next = S_PROD;
            S_PROD: state_next = S_SUM;
            S_SUM:
            begin
                if (num_reg == '0 || kind_reg == rau_pkg::KIND_CMP ||
                    kind_reg > rau_pkg::KIND_CMP)
                    state_next = S_OUT;
                else if (gy_reg == '0)
                begin
                    state_next = S_DIVN;
                    dctl.start = 1'b1;
                    dv_a = num_reg;
                    dv_b = gx_reg;
                end
                else
                begin
                    state_next = S_GCD;
                    dctl.start = 1'b1;
                end
            end
            S_GCD:
            begin
                if (dctl.done)
                begin
                    if (dv_r == '0)
                    begin
                        state_next = S_DIVN;
                        dctl.start = 1'b1;
                        dv_a = num_reg;
                        dv_b = gy_reg;
                    end
                    else
                    begin
                        dctl.start = 1'b1;
                        dv_a = gy_reg;
                        dv_b = dv_r;
                    end
                end
            end
            S_DIVN:
            begin
                if (dctl.done)
                begin
                    state_next = S_DIVD;
                    dctl.start = 1'b1;
                    dv_a = den_reg;
                    dv_b = gcd_reg;
                end
            end
            S_DIVD: if (dctl.done) state_next = S_WAIT;
            S_WAIT: state_next = S_IDLE;
            S_OUT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    rau_divider #(.W(MW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dctl.start),
        .dividend (dv_a),
        .divisor  (dv_b),
        .done     (dv_done),
        .quot     (dv_q),
        .rem      (dv_r)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_OUT) || (state_reg == S_WAIT);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                kind_reg <= kind;
                dz_reg   <= 1'b0;
                dneg_reg <= 1'b0;
                t2_reg   <= '0;
                t2n_reg  <= 1'b0;
                den_reg  <= MW'(1);
                case (kind)
                    rau_pkg::KIND_ADD, rau_pkg::KIND_SUB, rau_pkg::KIND_CMP:
                    begin
                        t1_reg   <= MW'(an_m * bd_m);
                        t1n_reg  <= an_s != bd_s;
                        t2_reg   <= MW'(bn_m * ad_m);
                        t2n_reg  <= (bn_s != ad_s) != (kind != rau_pkg::KIND_ADD);
                        den_reg  <= MW'(ad_m * bd_m);
                        dneg_reg <= ad_s != bd_s;
                    end
                    rau_pkg::KIND_MUL:
                    begin
                        t1_reg   <= MW'(an_m * bn_m);
                        t1n_reg  <= an_s != bn_s;
                        den_reg  <= MW'(ad_m * bd_m);
                        dneg_reg <= ad_s != bd_s;
                    end
                    rau_pkg::KIND_DIV:
                    begin
                        if (bn_m == '0)
                        begin
                            dz_reg  <= 1'b1;
                            t1_reg  <= '0;
                            t1n_reg <= 1'b0;
                        end
                        else
                        begin
                            t1_reg   <= MW'(an_m * bd_m);
                            t1n_reg  <= an_s != bd_s;
                            den_reg  <= MW'(bn_m * ad_m);
                            dneg_reg <= bn_s != ad_s;
                        end
                    end
                    rau_pkg::KIND_SCL:
                    begin
                        t1_reg   <= MW'(an_m * bn_m);
                        t1n_reg  <= an_s != bn_s;
                        den_reg  <= ad_w;
                        dneg_reg <= ad_s;
                    end
                    default:
                    begin
                        t1_reg  <= '0;
                        t1n_reg <= 1'b0;
                    end
                endcase
            end
            S_PROD:
            begin
                num_reg  <= sum_mag;
                nneg_reg <= sum_neg != dneg_reg;
                gx_reg   <= den_reg;
                gy_reg   <= sum_mag;
            end
            S_SUM:
            begin
                // gcd(num, den): start from den mod num; a zero remainder means num divides den.
                gx_reg <= den_reg;
                gy_reg <= num_reg;
                gcd_reg <= num_reg;
                eq_reg <= 1'b0;
                gt_reg <= 1'b0;
                lt_reg <= 1'b0;
                if (kind_reg == rau_pkg::KIND_CMP)
                begin
                    eq_reg <= num_reg == '0;
                    lt_reg <= num_reg != '0 && nneg_reg;
                    gt_reg <= num_reg != '0 && !nneg_reg;
                end
                if (num_reg == '0 || kind_reg == rau_pkg::KIND_CMP ||
                    kind_reg > rau_pkg::KIND_CMP)
                begin
                    rn_reg <= '0;
                    rd_reg <= rau_pkg::DEN_W'(1);
                end
            end
            S_GCD:
            begin
                if (dv_done)
                begin
                    gx_reg  <= gy_reg;
                    gy_reg  <= dv_r;
                    gcd_reg <= dv_r == '0 ? gy_reg : dv_r;
                end
            end
            S_DIVN:
            begin
                if (dv_done)
                    rn_reg <= nneg_reg ? -rau_pkg::NUM_W'(dv_q) : rau_pkg::NUM_W'(dv_q);
            end
            S_DIVD:
            begin
                if (dv_done)
                    rd_reg <= rau_pkg::DEN_W'(dv_q);
            end
            default:
            begin
            end
        endcase
    end

    assign busy       = state_reg != S_IDLE;
    assign done       = done_reg;
    assign res_num    = rn_reg;
    assign res_den    = rd_reg;
    assign is_equal   = eq_reg && done_reg;
    assign is_greater = gt_reg && done_reg;
    assign is_less    = lt_reg && done_reg;
    assign div_zero   = dz_reg;

    `RAU_ASSERT_IMP(a_flags_onehot, clk, rst_n, done_reg, $onehot0({eq_reg, gt_reg, lt_reg}), "flags")
    `RAU_ASSERT_IMP(a_den_nonzero, clk, rst_n, done_reg, res_den != '0, "zero denominator")
    `RAU_ASSERT_IMP(a_done_idle, clk, rst_n, done_reg, state_reg == S_IDLE, "strobe while busy")
endmodule

// ===== tb/rational_arithmetic_unit_tb.sv =====
// Self-checking testbench of the rational arithmetic unit: directed table, then random beats.
module rational_arithmetic_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [rau_pkg::NUM_W-1:0] num;
        logic [rau_pkg::DEN_W-1:0]        den;
        logic                             eq;
        logic                             gt;
        logic                             lt;
        logic                             dz;
    } fraction_t;

    typedef struct {
        logic [2:0]         kind;
        logic signed [15:0] an;
        logic signed [15:0] ad;
        logic signed [15:0] bn;
        logic signed [15:0] bd;
        bit                 typed;
        fraction_t          want;
    } row_t;

    localparam int RANDOM_BEATS = 1000;
    localparam int CALM_TAIL = 100;
    localparam longint CYCLE_LIMIT = 64'd15000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [2:0] kind = '0;
    logic signed [15:0] a_num = '0;
    logic signed [15:0] a_den = '0;
    logic signed [15:0] b_num = '0;
    logic signed [15:0] b_den = '0;
    logic busy;
    logic done;
    logic signed [rau_pkg::NUM_W-1:0] res_num;
    logic [rau_pkg::DEN_W-1:0] res_den;
    logic is_equal;
    logic is_greater;
    logic is_less;
    logic div_zero;

    fraction_t pending_fractions[$];
    row_t directed_rows[$];
    int mismatches = 0;
    int beats_sent = 0;
    int results_seen = 0;
    longint cycles = 0;

    rational_arithmetic_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
        .done(done), .res_num(res_num), .res_den(res_den), .is_equal(is_equal),
        .is_greater(is_greater), .is_less(is_less), .div_zero(div_zero)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_fractions.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic fraction_t reduce_fraction(logic [2:0] op, logic signed [15:0] an,
                                                  logic signed [15:0] ad,
                                                  logic signed [15:0] bn,
                                                  logic signed [15:0] bd);
        longint unsigned an_m, ad_m, bn_m, bd_m, t1_m, t2_m, num_m, den_m, x, y, r;
        bit an_s, ad_s, bn_s, bd_s, t1_s, t2_s, num_s, den_s;
        fraction_t f;
        an_s = an[15]; an_m = an_s ? 64'(-int'(an)) : 64'(an);
        bn_s = bn[15]; bn_m = bn_s ? 64'(-int'(bn)) : 64'(bn);
        ad_s = ad[15]; ad_m = ad_s ? 64'(-int'(ad)) : 64'(ad);
        bd_s = bd[15]; bd_m = bd_s ? 64'(-int'(bd)) : 64'(bd);
        // A zero denominator counts as one.
        if (ad_m == 0) ad_m = 1;
        if (bd_m == 0) bd_m = 1;
        num_s = 0; num_m = 0; den_m = 1; den_s = 0;
        f.eq = 0; f.gt = 0; f.lt = 0; f.dz = 0;
        case (op)
            rau_pkg::KIND_ADD, rau_pkg::KIND_SUB, rau_pkg::KIND_CMP:
            begin
                t1_s = an_s ^ bd_s;
                t1_m = an_m * bd_m;
                t2_s = bn_s ^ ad_s ^ (op != rau_pkg::KIND_ADD);
                t2_m = bn_m * ad_m;
                if (t1_s == t2_s)
                begin
                    num_s = t1_s; num_m = t1_m + t2_m;
                end
                else if (t1_m >= t2_m)
                begin
                    num_s = t1_s; num_m = t1_m - t2_m;
                end
                else
                begin
                    num_s = t2_s; num_m = t2_m - t1_m;
                end
                den_m = ad_m * bd_m; den_s = ad_s ^ bd_s;
            end
            rau_pkg::KIND_MUL:
            begin
                num_s = an_s ^ bn_s; num_m = an_m * bn_m;
                den_m = ad_m * bd_m; den_s = ad_s ^ bd_s;
            end
            rau_pkg::KIND_DIV:
            begin
                if (bn_m == 0)
                    f.dz = 1;
                else
                begin
                    num_s = an_s ^ bd_s; num_m = an_m * bd_m;
                    den_m = bn_m * ad_m; den_s = bn_s ^ ad_s;
                end
            end
            rau_pkg::KIND_SCL:
            begin
                num_s = an_s ^ bn_s; num_m = an_m * bn_m;
                den_m = ad_m; den_s = ad_s;
            end
            default:
            begin
                num_m = 0;
            end
        endcase
        num_s = num_s ^ den_s;
        if (op == rau_pkg::KIND_CMP)
        begin
            if (num_m == 0) f.eq = 1;
            else if (num_s) f.lt = 1;
            else f.gt = 1;
            num_m = 0;
        end
        if (num_m == 0)
        begin
            num_s = 0; den_m = 1;
        end
        else
        begin
            x = num_m; y = den_m;
            while (y != 0)
            begin
                r = x % y; x = y; y = r;
            end
            num_m = num_m / x; den_m = den_m / x;
        end
        f.num = num_s ? rau_pkg::NUM_W'(-num_m) : rau_pkg::NUM_W'(num_m);
        f.den = rau_pkg::DEN_W'(den_m);
        return f;
    endfunction

    function automatic fraction_t plain(logic signed [rau_pkg::NUM_W-1:0] n,
                                        logic [rau_pkg::DEN_W-1:0] d,
                                        logic eq, logic gt, logic lt, logic dz);
        fraction_t f;
        f.num = n; f.den = d; f.eq = eq; f.gt = gt; f.lt = lt; f.dz = dz;
        return f;
    endfunction

    task automatic add_row(logic [2:0] k, int an, int ad, int bn, int bd, bit typed,
                           fraction_t want);
        row_t r;
        r.kind = k; r.an = an[15:0]; r.ad = ad[15:0]; r.bn = bn[15:0]; r.bd = bd[15:0];
        r.typed = typed; r.want = want;
        directed_rows.push_back(r);
    endtask

    // Picks an operand value: full range, small values, or an extreme.
    function automatic logic signed [15:0] pick_operand();
        int sel;
        int extremes[6] = '{-32768, 32767, 0, 1, -1, -32767};
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return 16'($urandom());
        else if (sel < 8)
            return 16'($signed($urandom_range(0, 40)) - 20);
        else
            return 16'(extremes[$urandom_range(0, 5)]);
    endfunction

    // Drives one beat and returns once it has been taken.
    task automatic send_beat(row_t r, bit allow_gap);
        int gap;
        if (allow_gap && $urandom_range(0, 2) == 0)
        begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        kind <= r.kind; a_num <= r.an; a_den <= r.ad; b_num <= r.bn; b_den <= r.bd;
        do
            @(posedge clk);
        while (busy);
        pending_fractions.push_back(r.typed ? r.want
                                    : reduce_fraction(r.kind, r.an, r.ad, r.bn, r.bd));
        beats_sent++;
    endtask

    always @(posedge clk)
    begin
        fraction_t w;
        if (rst_n && done)
        begin
            results_seen++;
            if (pending_fractions.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Result %0d/%0d with no beat outstanding", res_num, res_den);
            end
            else
            begin
                w = pending_fractions.pop_front();
                if (res_num !== w.num || res_den !== w.den || is_equal !== w.eq ||
                    is_greater !== w.gt || is_less !== w.lt || div_zero !== w.dz)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Mismatch at result %0d: want %0d/%0d eq%b gt%b lt%b dz%b,",
                                  " got %0d/%0d eq%b gt%b lt%b dz%b"},
                                 results_seen, w.num, w.den, w.eq, w.gt, w.lt, w.dz,
                                 res_num, res_den, is_equal, is_greater, is_less,
                                 div_zero);
                end
            end
        end
    end

    initial
    begin
        row_t r;
        fraction_t none;
        none = plain(0, 1, 0, 0, 0, 0);
        add_row(rau_pkg::KIND_ADD, 0, 0, 0, 0, 1, none);
        add_row(rau_pkg::KIND_ADD, 1, 2, 1, 3, 0, none);
        add_row(rau_pkg::KIND_ADD, 32767, 1, 32767, 1, 1, plain(65534, 1, 0, 0, 0, 0));
        add_row(rau_pkg::KIND_ADD, 32767, -32768, -32768, 32767, 0, none);
        add_row(rau_pkg::KIND_SUB, 5, 7, 5, 7, 1, none);
        add_row(rau_pkg::KIND_SUB, -32768, 1, 32767, 1, 1, plain(-65535, 1, 0, 0, 0, 0));
        add_row(rau_pkg::KIND_SUB, 3, -4, -7, 6, 0, none);
        add_row(rau_pkg::KIND_MUL, -32768, 1, -32768, 1, 1,
                plain(1073741824, 1, 0, 0, 0, 0));
        add_row(rau_pkg::KIND_MUL, 1, -32768, 1, -32768, 1,
                plain(1, 1073741824, 0, 0, 0, 0));
        add_row(rau_pkg::KIND_MUL, 6, -9, 12, 0, 0, none);
        add_row(rau_pkg::KIND_DIV, 3, 4, 0, 5, 1, plain(0, 1, 0, 0, 0, 1));
        add_row(rau_pkg::KIND_DIV, 32767, 0, 0, -32768, 1, plain(0, 1, 0, 0, 0, 1));
        add_row(rau_pkg::KIND_DIV, -32768, 32767, 32767, -32768, 0, none);
        add_row(rau_pkg::KIND_DIV, 2, 3, -4, 9, 0, none);
        add_row(rau_pkg::KIND_SCL, 32767, -32768, -32768, 5, 0, none);
        add_row(rau_pkg::KIND_SCL, 7, 14, 0, 1, 1, none);
        add_row(rau_pkg::KIND_SCL, -3, 0, -1, 0, 1, plain(3, 1, 0, 0, 0, 0));
        add_row(rau_pkg::KIND_CMP, 1, 2, 2, 4, 1, plain(0, 1, 1, 0, 0, 0));
        add_row(rau_pkg::KIND_CMP, 32767, 1, -32768, 1, 1, plain(0, 1, 0, 1, 0, 0));
        add_row(rau_pkg::KIND_CMP, 1, -2, 1, 2, 1, plain(0, 1, 0, 0, 1, 0));
        add_row(rau_pkg::KIND_CMP, 0, 0, 0, -5, 1, plain(0, 1, 1, 0, 0, 0));
        add_row(3'd6, 100, 3, 7, 9, 1, none);
        add_row(3'd7, -32768, -32768, -32768, -32768, 1, none);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[i])
            send_beat(directed_rows[i], 1);
        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            r.kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                   : 3'($urandom_range(0, 5));
            r.an = pick_operand(); r.ad = pick_operand();
            r.bn = pick_operand(); r.bd = pick_operand();
            r.typed = 0; r.want = none;
            send_beat(r, i < RANDOM_BEATS - CALM_TAIL);
        end
        start <= 1'b0;
        while (pending_fractions.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Sent %0d beats (%0d directed: all six operations, undefined kinds,",
                 beats_sent, directed_rows.size());
        $display("zero divisors, operand extremes); checked %0d results, %0d mismatches",
                 results_seen, mismatches);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== rational_arithmetic_unit.f =====
+incdir+sv
sv/rau_pkg.sv
sv/rau_divider.sv
sv/rational_arithmetic_unit.sv
tb/rational_arithmetic_unit_tb.sv
